@@ sv/vlcb_pkg.sv @@
// shared types, constants and arithmetic helpers for the vertex light color blend
`default_nettype none

package vlcb_pkg;

   // fixed point format of the tint and channel values
   localparam int FRACTION_BITS = 16;
   localparam longint ONE = longint'(1) << FRACTION_BITS;

   // time of day register
   localparam int RATIO_W = 10;
   localparam int RATIO_MAX = 1000;
   localparam int RATIO_RST = 1000;
   localparam int QUO_W = 10;

   // tint constants
   localparam longint C04 = (4 * ONE + 50) / 100;
   localparam longint C078 = (78 * ONE + 500) / 1000;
   localparam longint ART = (104 * ONE + 50) / 100;
   localparam longint ART255 = 255 * ART;

   // ratio*ONE/1000 = ratio*A_RG + (ratio*B_RG)/1000
   localparam longint A_RG = ONE / 1000;
   localparam longint B_RG = ONE % 1000;
   // 98*ratio*ONE/100000 = ratio*A_B + (ratio*B_B)/100000
   localparam longint A_B = (98 * ONE) / 100000;
   localparam longint B_B = (98 * ONE) % 100000;

   // reciprocal constants for the small constant divisions
   localparam int Y_RG_W = 20;
   localparam int Y_B_W = 27;
   localparam int S_RG = 32;
   localparam int S_B = 44;
   localparam int M_RG_W = 23;
   localparam int M_B_W = 28;
   localparam longint M_RG = ((longint'(1) << S_RG) + 999) / 1000;
   localparam longint M_B = ((longint'(1) << S_B) + 99999) / 100000;

   // datapath widths
   localparam int SUN_W = FRACTION_BITS + 2;
   localparam int NUM_W = FRACTION_BITS + 10;
   localparam int U_W = FRACTION_BITS + 9;
   localparam int MIX_W = FRACTION_BITS + 1;
   localparam int CH_W = FRACTION_BITS + 2;
   localparam int LVL_W = CH_W + 2;

   // byte digits of a /255 operand and width of its leftover
   localparam int DIG_K = (U_W + 7) / 8;
   localparam int REM_W = $clog2((DIG_K + 2) * 255);

   // dark blue boost values, table*ONE/255
   localparam longint BOOST_1 = (1 * ONE) / 255;
   localparam longint BOOST_2 = (2 * ONE) / 255;
   localparam longint BOOST_3 = (3 * ONE) / 255;
   localparam longint BOOST_4 = (4 * ONE) / 255;
   localparam longint BOOST_5 = (5 * ONE) / 255;
   localparam longint BOOST_6 = (6 * ONE) / 255;

   typedef struct packed {
      logic [7:0] day_level;
      logic [7:0] night_level;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   // first estimate of u/255: sum of byte shifts, short by at most DIG_K
   function automatic logic [U_W-1:0] div255_est(input logic [U_W-1:0] u);
      logic [U_W-1:0] acc;
      acc = '0;
      for (int k = 1; k <= DIG_K; k++) begin
         acc = acc + (u >> (8 * k));
      end
      return acc;
   endfunction

   // exact u/255 from the estimate: small leftover divided by the 16-bit trick
   function automatic logic [U_W-1:0] div255_fix(input logic [U_W-1:0] u,
                                                 input logic [U_W-1:0] q0);
      logic [U_W-1:0] r_full;
      logic [REM_W-1:0] r;
      logic [REM_W:0] t;
      r_full = u - (q0 << 8) + q0;
      r = r_full[REM_W-1:0];
      t = {1'b0, r} + (REM_W+1)'(1) + (REM_W+1)'(r >> 8);
      return q0 + U_W'(t >> 8);
   endfunction

   // channel*255/ONE, clamped to a byte; negative gives 0
   function automatic logic [7:0] clamp_out(input logic signed [CH_W:0] v);
      logic [CH_W:0] m;
      logic [CH_W+8:0] p;
      logic [CH_W+8:0] t;
      logic [7:0] res;
      m = v;
      p = {m, 8'd0} - {8'd0, m};
      t = p >> FRACTION_BITS;
      if (v[CH_W]) begin
         res = 8'd0;
      end else if (t > (CH_W+9)'(255)) begin
         res = 8'hFF;
      end else begin
         res = t[7:0];
      end
      return res;
   endfunction

   // extra blue for dark levels, indexed by level/8
   function automatic logic [FRACTION_BITS-1:0] dark_boost(input logic [4:0] idx);
      logic [FRACTION_BITS-1:0] res;
      case (idx) inside
         5'd0, 5'd9:       res = FRACTION_BITS'(BOOST_1);
         5'd1, 5'd6:       res = FRACTION_BITS'(BOOST_4);
         5'd2, 5'd3, 5'd4: res = FRACTION_BITS'(BOOST_6);
         5'd5:             res = FRACTION_BITS'(BOOST_5);
         5'd7:             res = FRACTION_BITS'(BOOST_3);
         5'd8:             res = FRACTION_BITS'(BOOST_2);
         default:          res = '0;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

@@ sv/vertex_light_color_blend.sv @@
// vertex light pair to rgb color: alpha divider, tint mix and dark blue boost pipeline
//
//  channel   ports                        direction  handshake
//  request   start, busy, req_item        in         start & !busy
//  response  rsp_strobe, rsp_item         out        rsp_strobe, one cycle, no back pressure
//  config    csr_we, csr_wdata            in         csr_we, time of day ratio
//
// one transaction per cycle; each result is strobed once it has passed the 16 register stages
// (input stage included): three for the alpha divider, two byte-digit /255 passes per
// product and the level, boost and clamp.
// a ratio write reaches the mixing stage through the tint precompute registers; a
// transaction taken in the same cycle as the write already sees the new ratio.
// busy is high during reset and the cycle after; the pipeline never stalls.
`default_nettype none

module vertex_light_color_blend (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  vlcb_pkg::req_type                req_item,
   output logic                             rsp_strobe,
   output vlcb_pkg::rsp_type                rsp_item,
   input  logic                             csr_we,
   input  logic [vlcb_pkg::RATIO_W-1:0]     csr_wdata
);

   localparam int STAGES = 16;
   localparam int SUN_W = vlcb_pkg::SUN_W;
   localparam int NUM_W = vlcb_pkg::NUM_W;
   localparam int U_W = vlcb_pkg::U_W;
   localparam int MIX_W = vlcb_pkg::MIX_W;
   localparam int CH_W = vlcb_pkg::CH_W;
   localparam int LVL_W = vlcb_pkg::LVL_W;
   localparam int FB = vlcb_pkg::FRACTION_BITS;
   localparam int Y_RG_W = vlcb_pkg::Y_RG_W;
   localparam int Y_B_W = vlcb_pkg::Y_B_W;
   localparam int P_RG_W = Y_RG_W + vlcb_pkg::M_RG_W;
   localparam int P_B_W = Y_B_W + vlcb_pkg::M_B_W;
   localparam int QUO_W = vlcb_pkg::QUO_W;

   // control
   logic                 busy_ff;
   logic                 accept;
   logic [STAGES-1:0]    vld_ff;

   // config and tint precompute
   logic [vlcb_pkg::RATIO_W-1:0] ratio_ff;
   logic [vlcb_pkg::RATIO_W-1:0] rsat;
   logic [Y_RG_W-1:0]    cy_rg_in, cy_rg_ff;
   logic [Y_B_W-1:0]     cy_b_in, cy_b_ff;
   logic [SUN_W-1:0]     cbase_rg_in, cbase_rg_ff, cbase2_rg_ff;
   logic [SUN_W-1:0]     cbase_b_in, cbase_b_ff, cbase2_b_ff;
   logic [P_RG_W-1:0]    cprod_rg;
   logic [P_B_W-1:0]     cprod_b;
   logic [QUO_W-1:0]     cq_rg_in, cq_rg_ff, cq_b_in, cq_b_ff;
   logic signed [SUN_W-1:0] cd_rg_in, cd_rg_ff, cd_b_in, cd_b_ff;

   // alpha divider stages
   logic [7:0]           dayd;
   logic [7:0]           sum;
   logic [15:0]          rem1_in, rem1_ff, rem2_in, rem2_ff, rem3_in, rem3_ff;
   logic [7:0]           sum1_ff, sum2_ff, sum3_ff;
   logic                 zero1_ff, zero2_ff, zero3_ff;
   logic [7:0]           grey1_ff, grey2_ff, grey3_ff, grey4_ff, grey5_ff;
   logic [7:0]           grey6_ff, grey7_ff, grey8_ff;
   logic [2:0]           quo2_in, quo2_ff;
   logic [5:0]           quo3_in, quo3_ff;
   logic [7:0]           alpha4_in, alpha4_ff;

   // mix and channel lanes: 0 is red/green, 1 is blue
   logic signed [NUM_W-1:0] num5_in [2];
   logic signed [NUM_W-1:0] num5_ff [2];
   logic [U_W-1:0]       mag6_in [2];
   logic [U_W-1:0]       mag6_ff [2];
   logic [U_W-1:0]       mag7_ff [2];
   logic [U_W-1:0]       est7_ff [2];
   logic [MIX_W-1:0]     mix8_ff [2];
   logic [U_W-1:0]       prod9_ff [2];
   logic [U_W-1:0]       prod10_ff [2];
   logic [U_W-1:0]       est10_ff [2];
   logic [MIX_W-1:0]     chm11_ff [2];
   logic signed [CH_W-1:0] chs12_in [2];
   logic signed [CH_W-1:0] chs12_ff [2];
   logic                 neg6_ff [2];
   logic                 neg7_ff [2];
   logic                 neg8_ff [2];
   logic                 neg9_ff [2];
   logic                 neg10_ff [2];
   logic                 neg11_ff [2];

   // level, boost and output
   logic signed [LVL_W-1:0] lsum13_in, lsum13_ff;
   logic [7:0]           red13_ff, red14_ff, red15_ff;
   logic signed [CH_W-1:0] chb13_ff, chb14_ff;
   logic [LVL_W+6:0]     lprod;
   logic [LVL_W+6:0]     lshift;
   logic [7:0]           level;
   logic [FB-1:0]        boost14_in, boost14_ff;
   logic signed [CH_W:0] chb15_in, chb15_ff;
   vlcb_pkg::rsp_type    rsp_item_in, rsp_item_ff;

   // handshake and valid chain
   assign accept = start & ~busy_ff;
   assign busy = busy_ff;
   assign rsp_strobe = vld_ff[STAGES-1];
   assign rsp_item = rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         vld_ff <= '0;
      end else begin
         busy_ff <= 1'b0;
         vld_ff <= {vld_ff[STAGES-2:0], accept};
      end
   end

   // time of day ratio register
   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= vlcb_pkg::RATIO_W'(vlcb_pkg::RATIO_RST);
      end else if (csr_we) begin
         ratio_ff <= csr_wdata;
      end
   end

   // tint precompute: split products, reciprocal divide, then offset
   always_comb begin
      rsat = (ratio_ff > vlcb_pkg::RATIO_W'(vlcb_pkg::RATIO_MAX))
           ? vlcb_pkg::RATIO_W'(vlcb_pkg::RATIO_MAX) : ratio_ff;
      cy_rg_in = Y_RG_W'(rsat) * Y_RG_W'(vlcb_pkg::B_RG);
      cy_b_in = Y_B_W'(rsat) * Y_B_W'(vlcb_pkg::B_B);
      cbase_rg_in = SUN_W'(rsat) * SUN_W'(vlcb_pkg::A_RG);
      cbase_b_in = SUN_W'(rsat) * SUN_W'(vlcb_pkg::A_B);
      cprod_rg = P_RG_W'(cy_rg_ff) * P_RG_W'(vlcb_pkg::M_RG);
      cprod_b = P_B_W'(cy_b_ff) * P_B_W'(vlcb_pkg::M_B);
      cq_rg_in = cprod_rg[vlcb_pkg::S_RG +: QUO_W];
      cq_b_in = cprod_b[vlcb_pkg::S_B +: QUO_W];
      // sun tint minus the artificial tint
      cd_rg_in = cbase2_rg_ff + SUN_W'(cq_rg_ff)
               - SUN_W'(vlcb_pkg::C04 + vlcb_pkg::ART);
      cd_b_in = cbase2_b_ff + SUN_W'(cq_b_ff) + SUN_W'(vlcb_pkg::C078)
              - SUN_W'(vlcb_pkg::ART);
   end

   always_ff @(posedge clock) begin
      cy_rg_ff <= cy_rg_in;
      cy_b_ff <= cy_b_in;
      cbase_rg_ff <= cbase_rg_in;
      cbase_b_ff <= cbase_b_in;
      cq_rg_ff <= cq_rg_in;
      cq_b_ff <= cq_b_in;
      cbase2_rg_ff <= cbase_rg_ff;
      cbase2_b_ff <= cbase_b_ff;
      cd_rg_ff <= cd_rg_in;
      cd_b_ff <= cd_b_in;
   end

   // stage 1: night removal, sum, divider dividend day*255
   always_comb begin
      dayd = (req_item.day_level < req_item.night_level)
           ? 8'd0 : req_item.day_level - req_item.night_level;
      sum = dayd + req_item.night_level;
      rem1_in = {dayd, 8'd0} - {8'd0, dayd};
   end

   // stages 2 to 4: restoring divide, three, three and two quotient bits
   always_comb begin
      logic [15:0] r;
      logic [15:0] sh;
      r = rem1_ff;
      quo2_in = '0;
      for (int i = 0; i < 3; i++) begin
         sh = 16'(sum1_ff) << (7 - i);
         if (r >= sh) begin
            r = r - sh;
            quo2_in[2-i] = 1'b1;
         end
      end
      rem2_in = r;
   end

   always_comb begin
      logic [15:0] r;
      logic [15:0] sh;
      r = rem2_ff;
      quo3_in = {quo2_ff, 3'd0};
      for (int i = 0; i < 3; i++) begin
         sh = 16'(sum2_ff) << (4 - i);
         if (r >= sh) begin
            r = r - sh;
            quo3_in[2-i] = 1'b1;
         end
      end
      rem3_in = r;
   end

   always_comb begin
      logic [15:0] r;
      logic [15:0] sh;
      r = rem3_ff;
      alpha4_in = {quo3_ff, 2'd0};
      for (int i = 0; i < 2; i++) begin
         sh = 16'(sum3_ff) << (1 - i);
         if (r >= sh) begin
            r = r - sh;
            alpha4_in[1-i] = 1'b1;
         end
      end
      if (zero3_ff) begin
         alpha4_in = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      rem1_ff <= rem1_in;
      sum1_ff <= sum;
      zero1_ff <= (sum == 8'd0);
      grey1_ff <= {sum[7:1], 1'b0};
      rem2_ff <= rem2_in;
      quo2_ff <= quo2_in;
      sum2_ff <= sum1_ff;
      zero2_ff <= zero1_ff;
      grey2_ff <= grey1_ff;
      rem3_ff <= rem3_in;
      quo3_ff <= quo3_in;
      sum3_ff <= sum2_ff;
      zero3_ff <= zero2_ff;
      grey3_ff <= grey2_ff;
      alpha4_ff <= alpha4_in;
      grey4_ff <= grey3_ff;
      grey5_ff <= grey4_ff;
      grey6_ff <= grey5_ff;
      grey7_ff <= grey6_ff;
      grey8_ff <= grey7_ff;
   end

   // stage 5: mix numerator alpha*(sun-art) + 255*art
   always_comb begin
      logic signed [NUM_W-1:0] a_ext;
      logic signed [NUM_W-1:0] d_ext [2];
      a_ext = NUM_W'(alpha4_ff);
      d_ext[0] = NUM_W'(cd_rg_ff);
      d_ext[1] = NUM_W'(cd_b_ff);
      for (int l = 0; l < 2; l++) begin
         num5_in[l] = a_ext * d_ext[l] + NUM_W'(vlcb_pkg::ART255);
      end
   end

   // stage 6: sign and magnitude; stage 12: sign restored on the channel
   always_comb begin
      for (int l = 0; l < 2; l++) begin
         mag6_in[l] = num5_ff[l][NUM_W-1] ? U_W'(-num5_ff[l]) : U_W'(num5_ff[l]);
         chs12_in[l] = neg11_ff[l] ? -CH_W'(chm11_ff[l]) : CH_W'(chm11_ff[l]);
      end
   end

   // stages 5 to 12 per lane: /255, grey product, /255
   always_ff @(posedge clock) begin
      for (int l = 0; l < 2; l++) begin
         num5_ff[l] <= num5_in[l];
         mag6_ff[l] <= mag6_in[l];
         neg6_ff[l] <= num5_ff[l][NUM_W-1];
         mag7_ff[l] <= mag6_ff[l];
         est7_ff[l] <= vlcb_pkg::div255_est(mag6_ff[l]);
         neg7_ff[l] <= neg6_ff[l];
         mix8_ff[l] <= MIX_W'(vlcb_pkg::div255_fix(mag7_ff[l], est7_ff[l]));
         neg8_ff[l] <= neg7_ff[l];
         prod9_ff[l] <= U_W'(grey8_ff) * U_W'(mix8_ff[l]);
         neg9_ff[l] <= neg8_ff[l];
         prod10_ff[l] <= prod9_ff[l];
         est10_ff[l] <= vlcb_pkg::div255_est(prod9_ff[l]);
         neg10_ff[l] <= neg9_ff[l];
         chm11_ff[l] <= MIX_W'(vlcb_pkg::div255_fix(prod10_ff[l], est10_ff[l]));
         neg11_ff[l] <= neg10_ff[l];
         chs12_ff[l] <= chs12_in[l];
      end
   end

   // stage 13: brightness sum r+g+b; stage 14: level and boost; stage 15: blue boost
   always_comb begin
      lsum13_in = (LVL_W'(chs12_ff[0]) <<< 1) + LVL_W'(chs12_ff[1]);
      lprod = (LVL_W+7)'(lsum13_ff) * (LVL_W+7)'(85);
      lshift = lprod >> FB;
      if (lsum13_ff[LVL_W-1]) begin
         level = 8'd0;
      end else if (lshift > (LVL_W+7)'(255)) begin
         level = 8'hFF;
      end else begin
         level = lshift[7:0];
      end
      boost14_in = vlcb_pkg::dark_boost(level[7:3]);
      chb15_in = (CH_W+1)'(chb14_ff) + (CH_W+1)'(boost14_ff);
      rsp_item_in.red = red15_ff;
      rsp_item_in.green = red15_ff;
      rsp_item_in.blue = vlcb_pkg::clamp_out(chb15_ff);
   end

   always_ff @(posedge clock) begin
      lsum13_ff <= lsum13_in;
      red13_ff <= vlcb_pkg::clamp_out((CH_W+1)'(chs12_ff[0]));
      chb13_ff <= chs12_ff[1];
      boost14_ff <= boost14_in;
      chb14_ff <= chb13_ff;
      red14_ff <= red13_ff;
      chb15_ff <= chb15_in;
      red15_ff <= red14_ff;
      rsp_item_ff <= rsp_item_in;
   end

`ifndef ASSERT_OFF
   // every accepted transaction yields a result after the full pipeline
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##STAGES rsp_strobe)
      else $error("accepted transaction gives no result strobe");

   // no result without an accepted transaction
   a_no_extra : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, STAGES))
      else $error("result strobe without accepted transaction");

   // red and green share one lane
   a_red_green : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_item.red == rsp_item.green))
      else $error("red and green differ");

   // an unlit vertex comes out black, boost included
   a_black : assert property (@(posedge clock) disable iff (reset)
      (accept && req_item.day_level == 8'd0 && req_item.night_level == 8'd0)
      |-> ##16 (rsp_strobe && rsp_item.red == 8'd0 && rsp_item.blue == 8'd0))
      else $error("unlit vertex is not black");
`endif

endmodule

`default_nettype wire
